// ----- rtl/pqigs_pkg.sv -----
package pqigs_pkg;

    localparam int NUM_CH     = 3;
    localparam int PIX_W      = 8;
    localparam int CARRY_W    = 7;
    localparam int SHIFT_W    = 3;

    // Reciprocal of the bin size, scaled by 2**RECIP_SHIFT and rounded up.
    // With 8-bit samples this makes floor(pix * magic >> 16) exact.
    localparam int RECIP_SHIFT = 16;
    localparam int MAGIC_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = PIX_W + MAGIC_W;

    localparam int FULL_SCALE   = 255;
    localparam int RESET_LEVELS = 16;
    localparam int RESET_BIN    = FULL_SCALE / RESET_LEVELS;
    localparam int RESET_MAGIC  = ((1 << RECIP_SHIFT) + RESET_BIN - 1) / RESET_BIN;

    // Restoring divider: one quotient bit per step over a 17-bit dividend.
    localparam int DIV_STEPS = MAGIC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic MODE_UNIFORM = 1'b0;
    localparam logic MODE_IGS     = 1'b1;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_LEVELS = 1'b1;

    typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_vec_t;

    typedef struct packed {
        logic               mode;
        logic [SHIFT_W-1:0] low_sh;
        logic [CARRY_W-1:0] low_mask;
        logic [MAGIC_W-1:0] magic;
    } lane_ctrl_t;

    // floor(log2(levels)) clamped to 1..7; zero counts as one.
    function automatic logic [SHIFT_W-1:0] igs_bits(input logic [PIX_W-1:0] lv);
        logic [SHIFT_W-1:0] k;
        k = SHIFT_W'(1);
        for (int i = 1; i < PIX_W; i++)
        begin
            if (lv[i])
            begin
                k = SHIFT_W'(i);
            end
        end
        return k;
    endfunction

endpackage

// ----- rtl/pqigs_recip.sv -----
module pqigs_recip (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pqigs_pkg::PIX_W-1:0]    levels,
    output logic                           busy,
    output logic [pqigs_pkg::MAGIC_W-1:0]  magic
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BIN  = 3'b010,
        ST_MAG  = 3'b100
    } state_t;

    localparam int MW = pqigs_pkg::MAGIC_W;
    localparam int PW = pqigs_pkg::PIX_W;
    localparam int CW = pqigs_pkg::DIV_CNT_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(pqigs_pkg::DIV_STEPS - 1);

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [PW-1:0]  rem_reg, rem_next;
    logic [MW-1:0]  dvd_reg, dvd_next;
    logic [MW-1:0]  quo_reg, quo_next;
    logic [PW-1:0]  dvs_reg, dvs_next;
    logic [MW-1:0]  magic_reg, magic_next;

    logic [PW:0]    rem_shift;
    logic           fits;
    logic [PW:0]    rem_sub;
    logic [PW-1:0]  rem_step;
    logic [MW-1:0]  quo_step;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign rem_shift = {rem_reg, dvd_reg[MW-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub   = fits ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
    assign rem_step  = rem_sub[PW-1:0];
    assign quo_step  = {quo_reg[MW-2:0], fits};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        magic_next = magic_reg;
        if (start)
        begin
            // bin = floor(255 / levels)
            state_next = ST_BIN;
            count_next = '0;
            rem_next   = '0;
            quo_next   = '0;
            dvd_next   = MW'(pqigs_pkg::FULL_SCALE);
            dvs_next   = (levels == '0) ? PW'(1) : levels;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                end
                ST_BIN:
                begin
                    rem_next = rem_step;
                    dvd_next = {dvd_reg[MW-2:0], 1'b0};
                    quo_next = quo_step;
                    count_next = count_reg + CW'(1);
                    if (count_reg == LAST_STEP)
                    begin
                        // magic = ceil(2**16 / bin) = floor((2**16 - 1 + bin) / bin)
                        state_next = ST_MAG;
                        count_next = '0;
                        rem_next   = '0;
                        quo_next   = '0;
                        dvs_next   = quo_step[PW-1:0];
                        dvd_next   = MW'((1 << pqigs_pkg::RECIP_SHIFT) - 1)
                                   + {{(MW-PW){1'b0}}, quo_step[PW-1:0]};
                    end
                end
                ST_MAG:
                begin
                    rem_next = rem_step;
                    dvd_next = {dvd_reg[MW-2:0], 1'b0};
                    quo_next = quo_step;
                    count_next = count_reg + CW'(1);
                    if (count_reg == LAST_STEP)
                    begin
                        magic_next = quo_step;
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            magic_reg <= MW'(pqigs_pkg::RESET_MAGIC);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            magic_reg <= magic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy  = (state_reg != ST_IDLE);
    assign magic = magic_reg;

endmodule

// ----- rtl/pqigs_lane.sv -----
module pqigs_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pqigs_pkg::lane_ctrl_t         ctrl,
    input  logic                          accept,
    input  logic                          image_start,
    input  logic [pqigs_pkg::PIX_W-1:0]   pix,
    output logic [pqigs_pkg::PIX_W-1:0]   level
);

    localparam int PW = pqigs_pkg::PIX_W;
    localparam int CW = pqigs_pkg::CARRY_W;
    localparam int RW = pqigs_pkg::PROD_W;

    logic [CW-1:0] carry_reg, carry_next;
    logic [CW-1:0] carry_eff;
    logic [PW-1:0] top_mask;
    logic          saturated;
    logic [PW:0]   sum;
    logic [PW-1:0] igs_level;
    logic [RW-1:0] product;
    logic [PW-1:0] uni_level;

    assign carry_eff = image_start ? '0 : carry_reg;
    assign top_mask  = ~{1'b0, ctrl.low_mask};
    assign saturated = (pix & top_mask) == top_mask;

    // Skip the carry when the top bits are all ones. A carry left over from a
    // wider split can still push the sum past 255, so shift the full sum.
    assign sum       = saturated ? {1'b0, pix}
                                 : ({1'b0, pix} + {{(PW+1-CW){1'b0}}, carry_eff});
    assign igs_level = PW'(sum >> ctrl.low_sh);

    assign product   = RW'(pix) * RW'(ctrl.magic);
    assign uni_level = product[pqigs_pkg::RECIP_SHIFT +: PW];

    assign level = (ctrl.mode == pqigs_pkg::MODE_IGS) ? igs_level : uni_level;

    always_comb
    begin
        carry_next = carry_reg;
        if (accept)
        begin
            if (ctrl.mode == pqigs_pkg::MODE_IGS)
            begin
                carry_next = sum[CW-1:0] & ctrl.low_mask;
            end
            else if (image_start)
            begin
                carry_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

endmodule

// ----- rtl/pixel_quantizer_uniform_igs.sv -----
// Channel   Direction  Handshake            Beat contents
// pixel     in         in_valid / in_stall  red_in, green_in, blue_in, image_start
// level     out        out_valid / out_stall red_out, green_out, blue_out
// config    in         APB psel/penable     mode at 0x0, levels at 0x4
//
// One pixel per cycle while in_stall is low; each result is registered.
// Three channel lanes run side by side and the merging stage registers their
// levels into an output register backed by one skid entry.
// A write to levels starts the reciprocal unit: 2 x 17 divider steps,
// during which in_stall stays high.
// Reset clears the carries and loads mode 0, levels 16 and their reciprocal.
// A stall on the output fills the skid entry, then holds in_stall high.
module pixel_quantizer_uniform_igs (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic        image_start,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NCH = pqigs_pkg::NUM_CH;
    localparam int PW  = pqigs_pkg::PIX_W;
    localparam int SW  = pqigs_pkg::SHIFT_W;
    localparam int CW  = pqigs_pkg::CARRY_W;

    // Configuration registers
    logic          mode_reg, mode_next;
    logic [PW-1:0] levels_reg, levels_next;
    logic          cfg_write;
    logic          cfg_idx;
    logic          recalc_start;

    // Reciprocal unit
    logic                          recip_busy;
    logic [pqigs_pkg::MAGIC_W-1:0] magic;

    // Lane control
    pqigs_pkg::lane_ctrl_t ctrl;
    logic [SW-1:0]         igs_k;
    logic [PW-1:0]         low_mask_full;

    // Datapath
    pqigs_pkg::pix_vec_t pix_in;
    pqigs_pkg::pix_vec_t lane_level;
    logic                accept;
    logic                take;

    // Output register and skid entry
    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    pqigs_pkg::pix_vec_t out_data_reg, out_data_next;
    pqigs_pkg::pix_vec_t skid_data_reg, skid_data_next;

    //--------------------------------------------------------------------
    // Configuration port: write on the access phase, reads are immediate.
    //--------------------------------------------------------------------
    assign pready       = 1'b1;
    assign cfg_write    = psel & penable & pwrite & pready;
    assign cfg_idx      = paddr[2];
    assign recalc_start = cfg_write & (cfg_idx == pqigs_pkg::REG_LEVELS);

    always_comb
    begin
        mode_next   = mode_reg;
        levels_next = levels_reg;
        if (cfg_write)
        begin
            unique case (cfg_idx)
                pqigs_pkg::REG_MODE:   mode_next   = pwdata[0];
                pqigs_pkg::REG_LEVELS: levels_next = pwdata[PW-1:0];
                default:               mode_next   = mode_reg;
            endcase
        end
    end

    assign prdata = (cfg_idx == pqigs_pkg::REG_LEVELS) ? {24'b0, levels_reg}
                                                       : {31'b0, mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= pqigs_pkg::MODE_UNIFORM;
            levels_reg <= PW'(pqigs_pkg::RESET_LEVELS);
        end
        else
        begin
            mode_reg   <= mode_next;
            levels_reg <= levels_next;
        end
    end

    //--------------------------------------------------------------------
    // Bin reciprocal: recomputed after every levels write.
    //--------------------------------------------------------------------
    pqigs_recip u_recip (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (recalc_start),
        .levels (levels_next),
        .busy   (recip_busy),
        .magic  (magic)
    );

    //--------------------------------------------------------------------
    // Lane control: IGS split point from levels, shared by all lanes.
    //--------------------------------------------------------------------
    assign igs_k         = pqigs_pkg::igs_bits(levels_reg);
    assign ctrl.mode     = mode_reg;
    assign ctrl.low_sh   = SW'(4'd8 - {1'b0, igs_k});
    assign low_mask_full = (PW'(1) << ctrl.low_sh) - PW'(1);
    assign ctrl.low_mask = low_mask_full[CW-1:0];
    assign ctrl.magic    = magic;

    //--------------------------------------------------------------------
    // Handshake: stall while the reciprocal runs or the skid entry is full.
    //--------------------------------------------------------------------
    assign in_stall = recip_busy | skid_valid_reg;
    assign accept   = in_valid & ~in_stall;
    assign take     = out_valid_reg & ~out_stall;

    assign pix_in[0] = red_in;
    assign pix_in[1] = green_in;
    assign pix_in[2] = blue_in;

    for (genvar c = 0; c < NCH; c++)
    begin : g_lane
        pqigs_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .accept      (accept),
            .image_start (image_start),
            .pix         (pix_in[c]),
            .level       (lane_level[c])
        );
    end

    //--------------------------------------------------------------------
    // Merge: collect the three lane levels into one output beat.
    //--------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        // Advance the skid entry into the output register once a beat leaves.
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        // A new beat only arrives with the skid entry empty.
        if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = lane_level;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = lane_level;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_data_reg[0];
    assign green_out = out_data_reg[1];
    assign blue_out  = out_data_reg[2];

endmodule
